FILE: hw/rtl/fsub_pkg.sv
// Shared types and constants for the truncating binary32 subtractor.
// No dependencies.
package fsub_pkg;
  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned MantBits = 24;
  localparam int unsigned LzBits   = 5;
  localparam int unsigned ExpWBits = 10;

  typedef struct packed {
    logic                bypass;
    logic [WordBits-1:0] bypass_word;
    logic                sign;
    logic [ExpBits-1:0]  exp;
    logic                eff_sub;
    logic [MantBits-1:0] mbig;
    logic [MantBits-1:0] msmall;
  } align_t;

  typedef struct packed {
    logic                bypass;
    logic [WordBits-1:0] bypass_word;
    logic                sign;
    logic [ExpBits-1:0]  exp;
    logic                eff_sub;
    logic [MantBits:0]   sum;
    logic [LzBits-1:0]   lz;
  } addsub_t;
endpackage

FILE: hw/rtl/fsub_align.sv
// Stage 1: unpack, zero cases, magnitude swap and alignment shift.
// Depends on fsub_pkg.
module fsub_align import fsub_pkg::*; (
  input  logic [WordBits-1:0] minuend_i,
  input  logic [WordBits-1:0] subtrahend_i,
  output align_t              align_o
);
  logic                sa, sb;
  logic [WordBits-2:0] ma, mb, big, sml;
  logic [ExpBits-1:0]  eb, es, d;
  logic [MantBits-1:0] ms_full;

  always_comb begin
    sa = minuend_i[WordBits-1];
    sb = subtrahend_i[WordBits-1];
    ma = minuend_i[WordBits-2:0];
    mb = subtrahend_i[WordBits-2:0];
    big = (ma >= mb) ? ma : mb;
    sml = (ma >= mb) ? mb : ma;
    eb = big[WordBits-2:FracBits];
    es = sml[WordBits-2:FracBits];
    d  = eb - es;
    ms_full = {1'b1, sml[FracBits-1:0]};
    align_o.sign    = (sa != sb) ? sa : ((ma > mb) ? sa : ~sb);
    align_o.exp     = eb;
    align_o.eff_sub = (sa == sb);
    align_o.mbig    = {1'b1, big[FracBits-1:0]};
    align_o.msmall  = (d >= ExpBits'(MantBits)) ? '0 : (ms_full >> d[LzBits-1:0]);
    align_o.bypass      = 1'b1;
    align_o.bypass_word = '0;
    if (ma == '0 && mb == '0) begin
      align_o.bypass_word = {sa & ~sb, {(WordBits-1){1'b0}}};
    end else if (mb == '0) begin
      align_o.bypass_word = minuend_i;
    end else if (ma == '0) begin
      align_o.bypass_word = {~sb, mb};
    end else if (sa == sb && ma == mb) begin
      align_o.bypass_word = '0;
    end else begin
      align_o.bypass = 1'b0;
    end
  end
endmodule

FILE: hw/rtl/fsub_addsub.sv
// Stage 2: mantissa add or subtract and leading-zero count.
// Depends on fsub_pkg.
module fsub_addsub import fsub_pkg::*; (
  input  align_t  align_i,
  output addsub_t addsub_o
);
  logic [MantBits:0] sum;
  logic [LzBits-1:0] lz;

  always_comb begin
    sum = align_i.eff_sub ? ({1'b0, align_i.mbig} - {1'b0, align_i.msmall})
                          : ({1'b0, align_i.mbig} + {1'b0, align_i.msmall});
    lz = '0;
    for (int i = 0; i < MantBits; i++) begin
      if (sum[i]) lz = LzBits'(MantBits - 1 - i);
    end
    addsub_o.bypass      = align_i.bypass;
    addsub_o.bypass_word = align_i.bypass_word;
    addsub_o.sign        = align_i.sign;
    addsub_o.exp         = align_i.exp;
    addsub_o.eff_sub     = align_i.eff_sub;
    addsub_o.sum         = sum;
    addsub_o.lz          = lz;
  end
endmodule

FILE: hw/rtl/fsub_norm.sv
// Stage 3: normalize, saturate or flush the exponent, and pack the word.
// Depends on fsub_pkg.
module fsub_norm import fsub_pkg::*; (
  input  addsub_t             addsub_i,
  output logic [WordBits-1:0] word_o
);
  logic signed [ExpWBits-1:0] e;
  logic        [MantBits-1:0] m;

  always_comb begin
    if (addsub_i.eff_sub) begin
      m = addsub_i.sum[MantBits-1:0] << addsub_i.lz;
      e = $signed({2'b00, addsub_i.exp}) - $signed({5'b00000, addsub_i.lz});
    end else if (addsub_i.sum[MantBits]) begin
      m = addsub_i.sum[MantBits:1];
      e = $signed({2'b00, addsub_i.exp}) + 10'sd1;
    end else begin
      m = addsub_i.sum[MantBits-1:0];
      e = $signed({2'b00, addsub_i.exp});
    end
    if (addsub_i.bypass) begin
      word_o = addsub_i.bypass_word;
    end else if (e <= 10'sd0) begin
      word_o = '0;
    end else if (e > 10'sd255) begin
      word_o = {addsub_i.sign, {ExpBits{1'b1}}, {FracBits{1'b0}}};
    end else begin
      word_o = {addsub_i.sign, e[ExpBits-1:0], m[FracBits-1:0]};
    end
  end
endmodule

FILE: hw/rtl/float32_subtract_truncating_core.sv
// Top level of the truncating binary32 subtractor: three-stage pipeline.
// Depends on fsub_pkg, fsub_align, fsub_addsub, fsub_norm.
//
// Usage:
//   Input channel valid_i/ready_o carries minuend_i and subtrahend_i.
//   Output channel valid_o/ready_i carries difference_o = minuend - subtrahend,
//   dropping shifted-out bits; no NaN, infinity or subnormal handling.
//   A beat passes the align, add/subtract and normalize/pack stage registers
//   in that order, one register per stage, before valid_o rises.
//   Throughput: one beat per cycle while ready_i is high.
//   Stall: a low ready_i holds the output register; earlier stages keep
//   filling bubbles, and ready_o drops only once all three stages are full.
//   Reset: rst_ni clears all stage valid bits; the pipeline starts empty.
module float32_subtract_truncating_core import fsub_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [WordBits-1:0] minuend_i,
  input  logic [WordBits-1:0] subtrahend_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [WordBits-1:0] difference_o
);
  align_t              s1_d, s1_q;
  addsub_t             s2_d, s2_q;
  logic [WordBits-1:0] s3_d, s3_q;
  logic                v1_q, v2_q, v3_q;
  logic                adv1, adv2, adv3;

  assign adv3    = ~v3_q | ready_i;
  assign adv2    = ~v2_q | adv3;
  assign adv1    = ~v1_q | adv2;
  assign ready_o = adv1;

  fsub_align  u_align  (.minuend_i(minuend_i), .subtrahend_i(subtrahend_i), .align_o(s1_d));
  fsub_addsub u_addsub (.align_i(s1_q), .addsub_o(s2_d));
  fsub_norm   u_norm   (.addsub_i(s2_q), .word_o(s3_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
  end

  assign valid_o      = v3_q;
  assign difference_o = s3_q;
endmodule

FILE: tb/sv/float32_subtract_truncating_core_tb.sv
// Testbench for float32_subtract_truncating_core: drives operand pairs over valid/ready,
// predicts or looks up each truncated binary32 difference and compares beats in order.
// Depends on fsub_pkg and the core RTL.
module float32_subtract_truncating_core_tb;
  import fsub_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumRandom  = 950;
  localparam int unsigned WantDepth  = 1024;
  localparam logic [WordBits-1:0] SignBit = 32'h8000_0000;
  localparam logic [WordBits-1:0] HiddenOne = 32'h0080_0000;
  localparam logic [WordBits-1:0] FracMask = 32'h007F_FFFF;
  localparam logic [WordBits-1:0] MagMask = 32'h7FFF_FFFF;
  localparam logic [WordBits-1:0] NoCheck = 32'hDEAD_BEEF;
  localparam logic [WordBits-1:0] InfPos = 32'h7F80_0000;

  typedef struct packed {
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    logic                typed;
    logic [WordBits-1:0] want;
  } vec_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                valid_i = 1'b0;
  logic                ready_o;
  logic [WordBits-1:0] minuend_i = '0;
  logic [WordBits-1:0] subtrahend_i = '0;
  logic                valid_o;
  logic                ready_i = 1'b0;
  logic [WordBits-1:0] difference_o;

  logic [WordBits-1:0] want_diffs [WantDepth];
  int unsigned         wr_idx = 0;
  int unsigned         rd_idx = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         errors = 0;

  float32_subtract_truncating_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [WordBits-1:0] pack_word(logic s, int e, logic [WordBits-1:0] m);
    if (e <= 0) return '0;
    if (e > 255) return {s, 31'b0} | InfPos;
    return {s, e[7:0], m[22:0]};
  endfunction

  function automatic logic [WordBits-1:0] fsub_predict(logic [WordBits-1:0] a,
                                                      logic [WordBits-1:0] b);
    logic sa, sb, s;
    logic [WordBits-1:0] ma, mb, big, sml, mbig, msml, r;
    int unsigned d;
    int e;
    sa = a[31];
    sb = b[31];
    ma = a & MagMask;
    mb = b & MagMask;
    if (ma == 0 && mb == 0) return (sa && !sb) ? SignBit : '0;
    if (mb == 0) return a;
    if (ma == 0) return b ^ SignBit;
    big = (ma >= mb) ? ma : mb;
    sml = (ma >= mb) ? mb : ma;
    d = big[30:23] - sml[30:23];
    mbig = HiddenOne | (big & FracMask);
    msml = (d >= MantBits) ? '0 : ((HiddenOne | (sml & FracMask)) >> d);
    e = big[30:23];
    if (sa != sb) begin
      r = mbig + msml;
      if (r[24]) begin
        r = r >> 1;
        e++;
      end
      return pack_word(sa, e, r);
    end
    if (ma == mb) return '0;
    s = (ma > mb) ? sa : !sb;
    r = mbig - msml;
    while (!r[23]) begin
      r = r << 1;
      e--;
    end
    return pack_word(s, e, r);
  endfunction

  function automatic logic [WordBits-1:0] rand_operand();
    logic [WordBits-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'($urandom_range(0, 3));
      1: w[30:23] = 8'($urandom_range(252, 255));
      2: w[30:0] = '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic note_diff(logic [WordBits-1:0] d);
    want_diffs[wr_idx] = d;
    wr_idx++;
  endtask

  task automatic send_beat(logic [WordBits-1:0] a, logic [WordBits-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    minuend_i <= a;
    subtrahend_i <= b;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  task automatic run_pair(logic [WordBits-1:0] a, logic [WordBits-1:0] b);
    note_diff(fsub_predict(a, b));
    send_beat(a, b);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      if (rd_idx == wr_idx) begin
        $error("unexpected beat difference=%h", difference_o);
        errors++;
      end else begin
        if (difference_o !== want_diffs[rd_idx]) begin
          $error("difference expected %h actual %h", want_diffs[rd_idx], difference_o);
          errors++;
        end
        rd_idx++;
      end
    end
    ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("float32_subtract_truncating_core_tb: done, errors");
      $finish;
    end
  end

  vec_t directed[] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{32'h3F80_0000, 32'h0000_0000, 1'b1, 32'h3F80_0000},
    '{32'h8000_0000, 32'h3F80_0000, 1'b1, 32'hBF80_0000},
    '{32'h0000_0000, 32'hC120_0000, 1'b1, 32'h4120_0000},
    '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h7F80_0000},
    '{32'hFF80_0000, 32'h7F80_0000, 1'b1, 32'hFF80_0000},
    '{32'h4000_0000, 32'h3F80_0000, 1'b0, NoCheck},
    '{32'h3F80_0000, 32'h4000_0000, 1'b0, NoCheck},
    '{32'h3F80_0000, 32'hBF80_0000, 1'b0, NoCheck},
    '{32'h4B80_0000, 32'h3F80_0000, 1'b0, NoCheck},
    '{32'h4C00_0000, 32'h3F80_0000, 1'b0, NoCheck},
    '{32'h3F80_0001, 32'h3F80_0000, 1'b0, NoCheck},
    '{32'h0080_0001, 32'h0080_0000, 1'b0, NoCheck},
    '{32'h0000_0001, 32'h0000_0002, 1'b0, NoCheck},
    '{32'hBFFF_FFFF, 32'h3FFF_FFFF, 1'b0, NoCheck},
    '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0, NoCheck},
    '{32'h3F7F_FFFF, 32'h3F80_0000, 1'b0, NoCheck}
  };

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      note_diff(directed[i].typed ? directed[i].want
                : fsub_predict(directed[i].a, directed[i].b));
      send_beat(directed[i].a, directed[i].b);
    end
    for (n = 0; n < NumRandom; n++) begin
      case (n / (NumRandom / 4))
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if ($urandom_range(0, 3) == 0) run_pair(rand_operand(), rand_operand());
      else if ($urandom_range(0, 1) == 0) begin
        logic [WordBits-1:0] x;
        x = rand_operand();
        run_pair(x, {x[31] ^ 1'($urandom_range(0, 1)), x[30:23],
                     x[22:0] ^ 23'($urandom_range(0, 7))});
      end else run_pair($urandom, $urandom);
    end
    valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (rd_idx != wr_idx) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("float32_subtract_truncating_core_tb: done, clean");
    else $display("float32_subtract_truncating_core_tb: done, errors");
    $finish;
  end
endmodule
